// ===== rtl/bfr_pkg.sv =====
// Bitstream field reader package: field widths, request and status codes,
// and the decoded request record passed from front end to back end.
// No dependencies.
package bfr_pkg;

  localparam int STORE_BITS_DEF     = 64;
  localparam int MAX_FIELD_BITS_DEF = 32;

  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 6;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int HELD_W   = 7;
  localparam int PHASE_W  = 3;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GET  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Decoded request.
  typedef struct packed {
    logic               push;
    logic               field;
    logic               get;
    logic               too_long;
    logic [BYTE_W-1:0]  byte_in;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] rsh;
    logic [VALUE_W-1:0] ext_mask;
  } bfr_op_t;

endpackage

// ===== rtl/bfr_if.sv =====
// Request and result channel interfaces of the bitstream field reader.
// Depends on bfr_pkg.
interface bfr_in_if;
  logic                          valid;
  logic                          ready;
  logic [bfr_pkg::CMD_W-1:0]     cmd;
  logic [bfr_pkg::BYTE_W-1:0]    byte_in;
  logic [bfr_pkg::COUNT_W-1:0]   count;
  logic                          sign_extend;

  modport source (output valid, cmd, byte_in, count, sign_extend, input ready);
  modport sink   (input valid, cmd, byte_in, count, sign_extend, output ready);
endinterface

interface bfr_out_if;
  logic                          valid;
  logic                          ready;
  logic [bfr_pkg::VALUE_W-1:0]   value;
  logic                          byte_aligned;
  logic [bfr_pkg::STATUS_W-1:0]  status;
  logic [bfr_pkg::HELD_W-1:0]    bits_held;

  modport source (output valid, value, byte_aligned, status, bits_held, input ready);
  modport sink   (input valid, value, byte_aligned, status, bits_held, output ready);
endinterface

// ===== rtl/bitstream_field_reader.sv =====
// MSB-first bitstream field reader. Push requests append a byte to a bit
// store of STORE_BITS bits; peek and get requests return the next 0 to
// MAX_FIELD_BITS bits, right aligned, optionally sign extended, and get also
// consumes them. Every request gives exactly one result carrying status,
// byte alignment and the number of bits still held. One request is taken per
// cycle while results are taken; the back end executes each queued request
// and registers its result. That rate is set by the back end's funnel
// shifter, which reads and updates the bit store for one request per cycle.
// A two-entry queue separates request decode from execution, so requests can
// still be queued while a result waits. No clearing pass is needed after reset.
// Depends on bfr_pkg, bfr_if, bfr_front and bfr_back.
module bitstream_field_reader #(
  parameter int STORE_BITS     = bfr_pkg::STORE_BITS_DEF,
  parameter int MAX_FIELD_BITS = bfr_pkg::MAX_FIELD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bfr_in_if.sink     in_bus,
  bfr_out_if.source  out_bus
);

  logic             op_valid;
  logic             op_ready;
  bfr_pkg::bfr_op_t op;

  bfr_front #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op)
  );

  bfr_back #(
    .STORE_BITS (STORE_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op),
    .out_bus  (out_bus)
  );

`ifndef SYNTHESIS
  // Failed requests never carry a field value.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.status != bfr_pkg::ST_OK) |-> (out_bus.value == '0))
    else $error("nonzero value on failed request");

  // A full queue only happens while the back end has work waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> op_valid)
    else $error("request stalled with empty queue");

  // Every request executed shows up as a result the next cycle.
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    (op_valid && op_ready) |=> out_bus.valid)
    else $error("executed request produced no result");
`endif

endmodule

// ===== rtl/bfr_front.sv =====
// Front end: decodes requests and queues them in a two-entry FIFO.
// Depends on bfr_pkg and bfr_if.
module bfr_front #(
  parameter int MAX_FIELD_BITS = bfr_pkg::MAX_FIELD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  bfr_in_if.sink           in_bus,
  output logic             op_valid,
  input  logic             op_ready,
  output bfr_pkg::bfr_op_t op
);

  localparam logic [bfr_pkg::COUNT_W-1:0] FieldMax = bfr_pkg::COUNT_W'(MAX_FIELD_BITS);
  localparam logic [bfr_pkg::COUNT_W-1:0] ValueBits = bfr_pkg::COUNT_W'(bfr_pkg::VALUE_W);

  bfr_pkg::bfr_op_t dec;
  bfr_pkg::bfr_op_t q_r [2];
  logic             wr_r, wr_nxt;
  logic             rd_r, rd_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push_q, pop_q;

  always_comb begin
    dec          = '0;
    dec.push     = (in_bus.cmd == bfr_pkg::CMD_PUSH);
    dec.field    = (in_bus.cmd == bfr_pkg::CMD_PEEK) || (in_bus.cmd == bfr_pkg::CMD_GET);
    dec.get      = (in_bus.cmd == bfr_pkg::CMD_GET);
    dec.too_long = (in_bus.count > FieldMax);
    dec.byte_in  = in_bus.byte_in;
    dec.count    = in_bus.count;
    dec.rsh      = ValueBits - in_bus.count;
    dec.ext_mask = in_bus.sign_extend ? ~({bfr_pkg::VALUE_W{1'b1}} >> dec.rsh) : '0;
  end

  assign in_bus.ready = (cnt_r != 2'd2);
  assign push_q       = in_bus.valid && in_bus.ready;
  assign op_valid     = (cnt_r != 2'd0);
  assign pop_q        = op_valid && op_ready;
  assign op           = q_r[rd_r];

  always_comb begin
    wr_nxt  = push_q ? ~wr_r : wr_r;
    rd_nxt  = pop_q ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, push_q} - {1'b0, pop_q};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_q) begin
      q_r[wr_r] <= dec;
    end
  end

endmodule

// ===== rtl/bfr_back.sv =====
// Back end: holds the bit store, runs push/peek/get against it with a
// funnel shifter and registers one result per request.
// Depends on bfr_pkg and bfr_if.
module bfr_back #(
  parameter int STORE_BITS = bfr_pkg::STORE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             op_valid,
  output logic             op_ready,
  input  bfr_pkg::bfr_op_t op,
  bfr_out_if.source        out_bus
);

  localparam int FILL_W = $clog2(STORE_BITS + 1);
  localparam int CMP_W  = (FILL_W > bfr_pkg::COUNT_W) ? FILL_W : bfr_pkg::COUNT_W;
  localparam logic [FILL_W-1:0] PushLimit = FILL_W'(STORE_BITS - bfr_pkg::BYTE_W);
  localparam logic [FILL_W-1:0] ByteStep  = FILL_W'(bfr_pkg::BYTE_W);

  // Unread bits sit left aligned; everything below the fill level is zero.
  logic [STORE_BITS-1:0]          store_r, store_nxt;
  logic [FILL_W-1:0]              fill_r, fill_nxt;
  logic [bfr_pkg::PHASE_W-1:0]    phase_r, phase_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [bfr_pkg::VALUE_W-1:0]    value_r, value_nxt;
  logic                           aligned_r;
  logic [bfr_pkg::STATUS_W-1:0]   status_r, status_nxt;
  logic [bfr_pkg::HELD_W-1:0]     held_r;

  logic                           fire;
  logic [bfr_pkg::VALUE_W-1:0]    top;
  logic [bfr_pkg::VALUE_W-1:0]    field;
  logic                           short_f;
  logic                           full_f;
  logic [FILL_W-1:0]              psh;

  assign op_ready = !out_valid_r || out_bus.ready;
  assign fire     = op_valid && op_ready;

  always_comb begin
    top     = store_r[STORE_BITS-1 -: bfr_pkg::VALUE_W];
    field   = (top >> op.rsh) | (top[bfr_pkg::VALUE_W-1] ? op.ext_mask : '0);
    short_f = op.too_long || (CMP_W'(op.count) > CMP_W'(fill_r));
    full_f  = (fill_r > PushLimit);
    psh     = PushLimit - fill_r;

    store_nxt  = store_r;
    fill_nxt   = fill_r;
    phase_nxt  = phase_r;
    value_nxt  = '0;
    status_nxt = bfr_pkg::ST_OK;

    if (op.push) begin
      if (full_f) begin
        status_nxt = bfr_pkg::ST_FULL;
      end else begin
        store_nxt = store_r | (STORE_BITS'(op.byte_in) << psh);
        fill_nxt  = fill_r + ByteStep;
      end
    end else if (op.field) begin
      if (short_f) begin
        status_nxt = bfr_pkg::ST_SHORT;
      end else if (op.count != '0) begin
        value_nxt = field;
        if (op.get) begin
          store_nxt = store_r << op.count;
          fill_nxt  = fill_r - FILL_W'(op.count);
          phase_nxt = phase_r + op.count[bfr_pkg::PHASE_W-1:0];
        end
      end
    end

    out_valid_nxt = fire || (out_valid_r && !out_bus.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r     <= '0;
      fill_r      <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        store_r <= store_nxt;
        fill_r  <= fill_nxt;
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      value_r   <= value_nxt;
      aligned_r <= (phase_nxt == '0);
      status_r  <= status_nxt;
      held_r    <= bfr_pkg::HELD_W'(fill_nxt);
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.value        = value_r;
  assign out_bus.byte_aligned = aligned_r;
  assign out_bus.status       = status_r;
  assign out_bus.bits_held    = held_r;

endmodule

// ===== tb/bitstream_field_reader_checker.sv =====
// Checker for the bitstream field reader: watches the request and result
// channels, predicts each result from its own bit store copy and compares.
// Depends on bfr_pkg and bfr_if.
module bitstream_field_reader_checker (
  input  logic clk,
  input  logic rst_n,
  bfr_in_if    in_mon,
  bfr_out_if   out_mon,
  output int   mismatches,
  output int   pending,
  output int   results_checked,
  output int   fields_read,
  output int   shortages,
  output int   overflows
);

  typedef struct {
    logic [bfr_pkg::VALUE_W-1:0]  value;
    logic                         byte_aligned;
    logic [bfr_pkg::STATUS_W-1:0] status;
    logic [bfr_pkg::HELD_W-1:0]   bits_held;
  } field_result_t;

  field_result_t expected_q[$];
  field_result_t want;
  logic          stream_bits[$];
  int unsigned   consumed_phase;

  initial begin
    mismatches      = 0;
    pending         = 0;
    results_checked = 0;
    fields_read     = 0;
    shortages       = 0;
    overflows       = 0;
    consumed_phase  = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("mismatch: %s got %0h expected %0h at %0t", what, got, exp_val, $realtime);
    mismatches++;
  endtask

  // Applies one request to the bit store copy and returns its result.
  function automatic field_result_t read_stream(
      input logic [bfr_pkg::CMD_W-1:0]   cmd,
      input logic [bfr_pkg::BYTE_W-1:0]  data_byte,
      input logic [bfr_pkg::COUNT_W-1:0] count,
      input logic                        sign_extend);
    field_result_t r;
    logic [bfr_pkg::VALUE_W-1:0] v;
    int unsigned n;
    v = '0;
    n = 32'(count);
    r.status = bfr_pkg::ST_OK;
    case (cmd)
      bfr_pkg::CMD_PUSH: begin
        if (stream_bits.size() + 8 > bfr_pkg::STORE_BITS_DEF) begin
          r.status = bfr_pkg::ST_FULL;
        end else begin
          for (int k = bfr_pkg::BYTE_W - 1; k >= 0; k--) stream_bits.push_back(data_byte[k]);
        end
      end
      bfr_pkg::CMD_PEEK, bfr_pkg::CMD_GET: begin
        if (n > bfr_pkg::MAX_FIELD_BITS_DEF || n > stream_bits.size()) begin
          r.status = bfr_pkg::ST_SHORT;
        end else if (n > 0) begin
          for (int k = 0; k < n; k++) v = {v[bfr_pkg::VALUE_W-2:0], stream_bits[k]};
          if (sign_extend && v[n-1]) v = v | (32'hffffffff << n);
          if (cmd == bfr_pkg::CMD_GET) begin
            repeat (n) void'(stream_bits.pop_front());
            consumed_phase = (consumed_phase + n) & 7;
          end
        end
      end
      default: ;
    endcase
    r.value        = v;
    r.byte_aligned = (consumed_phase == 0);
    r.bits_held    = bfr_pkg::HELD_W'(stream_bits.size());
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(read_stream(in_mon.cmd, in_mon.byte_in, in_mon.count,
                                         in_mon.sign_extend));
      if (out_mon.valid && out_mon.ready) begin
        results_checked++;
        if (expected_q.size() == 0) begin
          report_mismatch("result with no request pending", out_mon.value, 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (want.status == bfr_pkg::ST_SHORT) shortages++;
          if (want.status == bfr_pkg::ST_FULL) overflows++;
          if (out_mon.value !== want.value)
            report_mismatch("value", out_mon.value, want.value);
          if (out_mon.byte_aligned !== want.byte_aligned)
            report_mismatch("byte_aligned", 32'(out_mon.byte_aligned),
                            32'(want.byte_aligned));
          if (out_mon.status !== want.status)
            report_mismatch("status", 32'(out_mon.status), 32'(want.status));
          else if (want.status == bfr_pkg::ST_OK && want.value != 0) fields_read++;
          if (out_mon.bits_held !== want.bits_held)
            report_mismatch("bits_held", 32'(out_mon.bits_held), 32'(want.bits_held));
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

// ===== tb/bitstream_field_reader_test.sv =====
// Testbench top for the bitstream field reader: clock, reset, request and
// result traffic with idle bursts and back-pressure, and the final verdict.
// Depends on bfr_pkg, bfr_if, bitstream_field_reader and its checker.
module bitstream_field_reader_test;

  localparam logic [bfr_pkg::CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 60;

  logic clk;
  logic rst_n;

  bfr_in_if  in_bus ();
  bfr_out_if out_bus ();

  int  mismatches, pending, results_checked, fields_read, shortages, overflows;
  int  quiet_cycles;
  int  stream_fill;
  int  sent;
  bit  in_idle_on;
  int  out_idle_pct;
  bit  hold_req;

  bitstream_field_reader dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  bitstream_field_reader_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_bus),
    .out_mon        (out_bus),
    .mismatches     (mismatches),
    .pending        (pending),
    .results_checked(results_checked),
    .fields_read    (fields_read),
    .shortages      (shortages),
    .overflows      (overflows)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: too long with no request or result moving.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no traffic for %0d cycles", quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Result side: random stall bursts plus one long hold on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        out_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < out_idle_pct) begin
        stall_left = $urandom_range(0, 11);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic [bfr_pkg::CMD_W-1:0]   cmd,
                              input logic [bfr_pkg::BYTE_W-1:0]  data_byte,
                              input logic [bfr_pkg::COUNT_W-1:0] count,
                              input logic                        sign_extend);
    @(negedge clk);
    in_bus.valid       <= 1'b1;
    in_bus.cmd         <= cmd;
    in_bus.byte_in     <= data_byte;
    in_bus.count       <= count;
    in_bus.sign_extend <= sign_extend;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sent++;
    // rough fill tracking, only to steer the random mix
    if (cmd == bfr_pkg::CMD_PUSH && stream_fill <= bfr_pkg::STORE_BITS_DEF - 8)
      stream_fill += 8;
    if (cmd == bfr_pkg::CMD_GET && count <= bfr_pkg::MAX_FIELD_BITS_DEF &&
        count <= stream_fill)
      stream_fill -= int'(count);
    if (in_idle_on && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk);
    end
  endtask

  task automatic random_request();
    int pick, push_pct, top;
    logic [bfr_pkg::CMD_W-1:0] cmd;
    logic [bfr_pkg::COUNT_W-1:0] count;
    pick = $urandom_range(0, 99);
    push_pct = (stream_fill < 24) ? 70 : (stream_fill > 48) ? 15 : 40;
    if (pick < push_pct) cmd = bfr_pkg::CMD_PUSH;
    else if (pick < 97)
      cmd = ($urandom_range(0, 9) < 6) ? bfr_pkg::CMD_GET : bfr_pkg::CMD_PEEK;
    else cmd = CMD_NONE;
    top = (stream_fill < bfr_pkg::MAX_FIELD_BITS_DEF) ? stream_fill :
                                                         bfr_pkg::MAX_FIELD_BITS_DEF;
    if ($urandom_range(0, 9) == 0) count = bfr_pkg::COUNT_W'($urandom_range(0, 63));
    else count = bfr_pkg::COUNT_W'($urandom_range(0, top));
    send_request(cmd, bfr_pkg::BYTE_W'($urandom_range(0, 255)), count,
                 1'($urandom_range(0, 1)));
  endtask

  task automatic drain();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    wait (pending == 0);
  endtask

  initial begin
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.cmd         = bfr_pkg::CMD_PUSH;
    in_bus.byte_in     = '0;
    in_bus.count       = '0;
    in_bus.sign_extend = 1'b0;
    quiet_cycles = 0;
    stream_fill  = 0;
    sent         = 0;
    in_idle_on   = 1'b0;
    out_idle_pct = 0;
    hold_req     = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty store, fill to the brim, overflow, field extremes
    send_request(bfr_pkg::CMD_GET,  8'h00, 6'd8,  1'b0);
    send_request(bfr_pkg::CMD_PEEK, 8'h00, 6'd0,  1'b1);
    send_request(bfr_pkg::CMD_PUSH, 8'hff, 6'd0,  1'b0);
    send_request(bfr_pkg::CMD_PUSH, 8'h80, 6'd0,  1'b0);
    send_request(bfr_pkg::CMD_PUSH, 8'h00, 6'd0,  1'b0);
    send_request(bfr_pkg::CMD_PUSH, 8'h7f, 6'd0,  1'b0);
    send_request(bfr_pkg::CMD_PUSH, 8'ha5, 6'd0,  1'b0);
    send_request(bfr_pkg::CMD_PUSH, 8'h3c, 6'd0,  1'b0);
    send_request(bfr_pkg::CMD_PUSH, 8'h01, 6'd0,  1'b0);
    send_request(bfr_pkg::CMD_PUSH, 8'hfe, 6'd0,  1'b0);
    send_request(bfr_pkg::CMD_PUSH, 8'h55, 6'd63, 1'b1);
    send_request(bfr_pkg::CMD_PEEK, 8'h00, 6'd32, 1'b1);
    send_request(bfr_pkg::CMD_PEEK, 8'h00, 6'd33, 1'b0);
    send_request(bfr_pkg::CMD_GET,  8'h00, 6'd63, 1'b1);
    send_request(bfr_pkg::CMD_GET,  8'h00, 6'd0,  1'b1);
    send_request(bfr_pkg::CMD_GET,  8'h00, 6'd1,  1'b1);
    send_request(bfr_pkg::CMD_GET,  8'h00, 6'd3,  1'b0);
    send_request(bfr_pkg::CMD_PEEK, 8'h00, 6'd5,  1'b1);
    send_request(bfr_pkg::CMD_PEEK, 8'h00, 6'd5,  1'b0);
    send_request(CMD_NONE,          8'hff, 6'd63, 1'b1);
    send_request(bfr_pkg::CMD_GET,  8'h00, 6'd32, 1'b0);
    send_request(bfr_pkg::CMD_GET,  8'h00, 6'd28, 1'b1);
    send_request(bfr_pkg::CMD_GET,  8'h00, 6'd1,  1'b0);
    stream_fill = 0;

    // random, idle bursts on both sides, one long result-side hold
    in_idle_on   = 1'b1;
    out_idle_pct = 10;
    for (int i = 0; i < 600; i++) begin
      if (i == 300) hold_req = 1'b1;
      random_request();
    end
    drain();

    // random, stalls only on the result side
    in_idle_on = 1'b0;
    for (int i = 0; i < 600; i++) random_request();
    drain();

    // random, back to back with no idling
    out_idle_pct = 0;
    for (int i = 0; i < 600; i++) random_request();
    drain();
    repeat (4) @(posedge clk);

    $display("sent %0d requests, checked %0d results", sent, results_checked);
    $display("nonzero fields %0d, shortages %0d, pushes dropped on a full store %0d",
             fields_read, shortages, overflows);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bfr_pkg.sv
rtl/bfr_if.sv
rtl/bfr_front.sv
rtl/bfr_back.sv
rtl/bitstream_field_reader.sv
tb/bitstream_field_reader_checker.sv
tb/bitstream_field_reader_test.sv
